FILE: src/rest_pkg.sv
// shared types and constants for the rotary encoder step tracker
package rest_pkg;

  localparam int COUNT_BITS = 32;
  localparam int COUNT_OUT_W = 32;
  localparam int MS_W = 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic [MS_W-1:0] ELAPSED_MAX = {MS_W{1'b1}};
  localparam logic [MS_W-1:0] LOCKOUT_RESET = MS_W'(10);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_EDGE = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [1:0] op;
    logic       pin_a_level;
    logic       pin_b_level;
  } item_t;

endpackage

FILE: src/rest_in_if.sv
// input channel: op code and sampled pin levels
interface rest_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic       pin_a_level;
  logic       pin_b_level;

  modport source(output valid, op, pin_a_level, pin_b_level, input ready);
  modport sink(input valid, op, pin_a_level, pin_b_level, output ready);
endinterface

FILE: src/rest_out_if.sv
// result channel: count, direction indicator and tracker phase
interface rest_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [rest_pkg::COUNT_OUT_W-1:0] count_value;
  logic                            direction_led;
  logic [1:0]                      tracker_phase;

  modport source(output valid, count_value, direction_led, tracker_phase, input ready);
  modport sink(input valid, count_value, direction_led, tracker_phase, output ready);
endinterface

FILE: src/rest_in_stage.sv
// input register stage holding one transaction ahead of the tracker core
module rest_in_stage (
  input  logic             clk,
  input  logic             rst,
  rest_in_if.sink          item,
  input  logic             take,
  output logic             stage_valid,
  output rest_pkg::item_t  stage_item
);

  assign item.ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage_item <= '{op: item.op, pin_a_level: item.pin_a_level,
                      pin_b_level: item.pin_b_level};
    end
  end

endmodule

FILE: src/rest_core.sv
// tracker state, lockout timing, step count and result register
module rest_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rest_pkg::MS_W-1:0]  cfg_wdata,
  input  logic                       stage_valid,
  input  rest_pkg::item_t            stage_item,
  output logic                       take,
  rest_out_if.source                 result
);

  rest_pkg::phase_t                    phase, phase_next;
  logic [rest_pkg::COUNT_BITS-1:0]     step_count, step_count_next;
  logic [rest_pkg::MS_W-1:0]           elapsed_ms, elapsed_ms_next;
  logic [rest_pkg::MS_W-1:0]           lockout_ms;
  logic                                indicator, indicator_next;
  logic                                a_on, b_on, edge_ok, is_read;

  assign take = stage_valid && (!result.valid || result.ready);

  // pins are pulled up, so low means active
  assign a_on    = !stage_item.pin_a_level;
  assign b_on    = !stage_item.pin_b_level;
  assign edge_ok = (stage_item.op == rest_pkg::OP_EDGE) && (elapsed_ms >= lockout_ms);
  assign is_read = (stage_item.op == rest_pkg::OP_READ);

  // next phase
  always_comb begin
    phase_next = phase;
    if (edge_ok) begin
      case (phase)
        rest_pkg::PH_IDLE: begin
          if (a_on && !b_on) phase_next = rest_pkg::PH_LEFT;
          else if (b_on && !a_on) phase_next = rest_pkg::PH_RIGHT;
        end
        rest_pkg::PH_LEFT, rest_pkg::PH_RIGHT: begin
          if (a_on && b_on) phase_next = rest_pkg::PH_IDLE;
        end
        default: phase_next = rest_pkg::PH_IDLE;
      endcase
    end
  end

  // count, indicator and elapsed time
  always_comb begin
    step_count_next = step_count;
    indicator_next  = indicator;
    elapsed_ms_next = elapsed_ms;
    if (is_read) begin
      step_count_next = '0;
    end
    if (edge_ok) begin
      case (phase)
        rest_pkg::PH_LEFT: begin
          indicator_next = 1'b1;
          if (a_on && b_on && step_count != rest_pkg::COUNT_MIN)
            step_count_next = step_count - rest_pkg::COUNT_BITS'(1);
        end
        rest_pkg::PH_RIGHT: begin
          indicator_next = 1'b0;
          if (a_on && b_on && step_count != rest_pkg::COUNT_MAX)
            step_count_next = step_count + rest_pkg::COUNT_BITS'(1);
        end
        default: ;
      endcase
    end
    if (phase_next != phase) begin
      elapsed_ms_next = '0;
    end else if (stage_item.op == rest_pkg::OP_TICK && elapsed_ms != rest_pkg::ELAPSED_MAX) begin
      elapsed_ms_next = elapsed_ms + rest_pkg::MS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_ms <= rest_pkg::LOCKOUT_RESET;
    end else if (cfg_we) begin
      lockout_ms <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= rest_pkg::PH_IDLE;
      step_count <= '0;
      elapsed_ms <= '0;
      indicator  <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      step_count <= step_count_next;
      elapsed_ms <= elapsed_ms_next;
      indicator  <= indicator_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.count_value   <= is_read ? rest_pkg::COUNT_OUT_W'(signed'(step_count)) : '0;
      result.direction_led <= indicator_next;
      result.tracker_phase <= phase_next;
    end
  end

  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    take && is_read |=> step_count == '0)
    else $error("count not cleared after read");

  a_transition_clears_elapsed: assert property (@(posedge clk) disable iff (rst)
    take && (phase_next != phase) |=> elapsed_ms == '0)
    else $error("elapsed time not cleared on transition");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !take |=> $stable(phase) && $stable(step_count) && $stable(indicator))
    else $error("tracker state moved without a transaction");

  a_lockout_blocks: assert property (@(posedge clk) disable iff (rst)
    take && stage_item.op == rest_pkg::OP_EDGE && elapsed_ms < lockout_ms
      |=> $stable(phase) && $stable(step_count) && $stable(indicator))
    else $error("edge acted on inside lockout window");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    take |=> result.valid && result.tracker_phase == phase
      && result.direction_led == indicator)
    else $error("result register disagrees with tracker state");

endmodule

FILE: src/rotary_encoder_step_tracker.sv
// an accepted transaction passes the input register and then the result register
// throughput: one transaction per cycle while results are taken; the input register
// and the result register let a new item in while a finished result waits to be taken
// reset clears phase to idle, count, elapsed time and indicator to zero,
// sets the lockout to 10 ms and empties both registers
module rotary_encoder_step_tracker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rest_pkg::MS_W-1:0] cfg_wdata,
  rest_in_if.sink                   item,
  rest_out_if.source                result
);

  logic            take;
  logic            stage_valid;
  rest_pkg::item_t stage_item;

  rest_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .take        (take),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  rest_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .take        (take),
    .result      (result)
  );

endmodule

FILE: dv/tb_rotary_encoder_step_tracker.sv
// self-checking testbench for the rotary encoder step tracker: predicts every reading
module tb_rotary_encoder_step_tracker;
  import rest_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 50;

  typedef struct {
    logic signed [COUNT_OUT_W-1:0] count;
    logic                          led;
    logic [1:0]                    phase;
  } reading_t;

  class step_count_checker;
    logic [MS_W-1:0]              lockout;
    logic [MS_W-1:0]              elapsed;
    phase_t                       phase;
    logic signed [COUNT_BITS-1:0] steps;
    logic                         indicator;
    reading_t                     pending_readings[$];
    int                           errors;

    function new();
      lockout = LOCKOUT_RESET;
      elapsed = '0;
      phase = PH_IDLE;
      steps = '0;
      indicator = 1'b0;
      errors = 0;
    endfunction

    function void set_lockout(logic [MS_W-1:0] value);
      lockout = value;
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    // track the encoder state and queue the reading this transaction produces
    function void note_item(item_t it);
      reading_t r;
      logic     a_on;
      logic     b_on;
      a_on = !it.pin_a_level;
      b_on = !it.pin_b_level;
      r.count = '0;
      case (it.op)
        OP_TICK: if (elapsed != ELAPSED_MAX) elapsed = elapsed + MS_W'(1);
        OP_EDGE: if (elapsed >= lockout) begin
          case (phase)
            PH_IDLE: begin
              if (a_on && !b_on) begin
                phase = PH_LEFT;
                elapsed = '0;
              end else if (b_on && !a_on) begin
                phase = PH_RIGHT;
                elapsed = '0;
              end
            end
            PH_LEFT: begin
              indicator = 1'b1;
              if (a_on && b_on) begin
                if (steps != COUNT_MIN) steps = steps - 1;
                phase = PH_IDLE;
                elapsed = '0;
              end
            end
            PH_RIGHT: begin
              indicator = 1'b0;
              if (a_on && b_on) begin
                if (steps != COUNT_MAX) steps = steps + 1;
                phase = PH_IDLE;
                elapsed = '0;
              end
            end
            default: ;
          endcase
        end
        OP_READ: begin
          r.count = COUNT_OUT_W'(steps);
          steps = '0;
        end
        default: ;
      endcase
      r.led = indicator;
      r.phase = phase;
      pending_readings.push_back(r);
    endfunction

    function void check_result(logic signed [COUNT_OUT_W-1:0] count, logic led,
                               logic [1:0] ph);
      reading_t r;
      if (pending_readings.size() == 0) begin
        $error("result with no transaction waiting: count_value %0d", count);
        errors++;
        return;
      end
      r = pending_readings.pop_front();
      if (count !== r.count) begin
        $error("count_value: expected %0d, actual %0d", r.count, count);
        errors++;
      end
      if (led !== r.led) begin
        $error("direction_led: expected %0b, actual %0b", r.led, led);
        errors++;
      end
      if (ph !== r.phase) begin
        $error("tracker_phase: expected %0d, actual %0d", r.phase, ph);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            cfg_we;
  logic [MS_W-1:0] cfg_wdata;

  rest_in_if  in_ch();
  rest_out_if out_ch();

  rotary_encoder_step_tracker dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .item     (in_ch),
    .result   (out_ch)
  );

  step_count_checker sb;
  int src_idle_pct;
  int sink_stall_pct;
  int pressure_req;
  int phase_items;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      sb.note_item('{op: in_ch.op, pin_a_level: in_ch.pin_a_level,
                     pin_b_level: in_ch.pin_b_level});
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.count_value, out_ch.direction_led, out_ch.tracker_phase);
    end
  end

  // receiver: random stalls, plus a long hold-off whenever one is requested
  initial begin
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_req != seen) begin
        seen = pressure_req;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic a, input logic b);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.pin_a_level <= a;
    in_ch.pin_b_level <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    phase_items++;
  endtask

  // drain every outstanding reading before touching the lockout register
  task automatic set_lockout(input logic [MS_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_lockout(value);
  endtask

  task automatic settle_ticks();
    int n;
    n = int'(sb.lockout) + $urandom_range(0, 2);
    // now and then stop one tick short so the next edge lands in the lockout
    if (sb.lockout != 0 && $urandom_range(0, 4) == 0) n = int'(sb.lockout) - 1;
    repeat (n) send_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic turn_detent();
    logic left;
    left = 1'($urandom_range(0, 1));
    settle_ticks();
    if (left) send_item(OP_EDGE, 1'b0, 1'b1);
    else send_item(OP_EDGE, 1'b1, 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      send_item(OP_EDGE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    settle_ticks();
    send_item(OP_EDGE, 1'b0, 1'b0);
    if ($urandom_range(0, 2) == 0) begin
      send_item(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic line_noise();
    repeat ($urandom_range(1, 4)) begin
      send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input logic [MS_W-1:0] lockout, input int src, input int snk,
                           input int n);
    src_idle_pct = src;
    sink_stall_pct <= snk;
    set_lockout(lockout);
    phase_items = 0;
    while (phase_items < n) begin
      if ($urandom_range(0, 4) == 0) line_noise();
      else turn_detent();
    end
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_TICK;
    in_ch.pin_a_level = 1'b1;
    in_ch.pin_b_level = 1'b1;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    pressure_req = 0;
    phase_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lockout after reset: edges are ignored until ten ticks have passed
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b1, 1'b0);
    send_item(OP_UNUSED, 1'b0, 1'b0);
    send_item(OP_READ, 1'b1, 1'b1);
    repeat (10) send_item(OP_TICK, 1'b1, 1'b1);
    send_item(OP_EDGE, 1'b0, 1'b1);

    // zero lockout: every edge counts
    set_lockout('0);
    send_item(OP_EDGE, 1'b1, 1'b1);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b1, 1'b1);
    send_item(OP_EDGE, 1'b1, 1'b0);
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b1, 1'b0);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_READ, 1'b0, 1'b1);
    send_item(OP_READ, 1'b1, 1'b0);

    run_phase(8'd0, 0, 0, 60);
    run_phase(8'd3, 78, 0, 60);
    run_phase(8'd1, 0, 78, 60);
    run_phase(MS_W'($urandom_range(0, 6)), 21, 21, 60);

    // receiver holds off while the sender keeps offering, so the block backs up
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    set_lockout(8'd2);
    pressure_req <= pressure_req + 1;
    phase_items = 0;
    while (phase_items < 60) turn_detent();

    // longest lockout: elapsed time has to saturate before an edge gets through
    src_idle_pct = 21;
    sink_stall_pct <= 21;
    set_lockout(ELAPSED_MAX);
    repeat (260) send_item(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    send_item(OP_EDGE, 1'b0, 1'b1);
    send_item(OP_EDGE, 1'b1, 1'b0);
    repeat (3) send_item(OP_TICK, 1'b0, 1'b0);
    send_item(OP_EDGE, 1'b0, 1'b0);
    send_item(OP_READ, 1'b1, 1'b1);

    run_phase(MS_W'($urandom_range(0, 4)), 78, 0, 60);
    run_phase(LOCKOUT_RESET, 0, 0, 60);

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("FAIL");
    $finish;
  end

endmodule
